>>> rtl/core/cpa_pkg.sv
// Package for the consensus profile accumulator.
// Holds the transaction payload types, the cluster table entry and the control struct.
// No dependencies.
package cpa_pkg;

    // Fixed value counts of the transaction fields and widths of the cluster entry fields.
    localparam int CLUSTER_FIELD_VALUES = 16;
    localparam int LETTER_FIELD_VALUES  = 4;
    localparam int LEN_BITS             = 9;
    localparam int MEMBER_BITS          = 16;
    localparam logic [MEMBER_BITS-1:0] MEMBER_MAX = {MEMBER_BITS{1'b1}};

    typedef struct packed {
        logic       action;
        logic [3:0] cluster;
        logic [7:0] position;
        logic [1:0] letter;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [1:0]  consensus_letter;
        logic [15:0] letter_count;
        logic [15:0] member_count;
        logic        ignored;
    } out_t;

    typedef struct packed {
        logic [LEN_BITS-1:0]    len;
        logic [MEMBER_BITS-1:0] members;
    } clu_entry_t;

    typedef struct packed {
        logic row_we;
        logic clu_we;
    } upd_ctl_t;

    localparam logic ACTION_SEED = 1'b0;
    localparam logic ACTION_ADD  = 1'b1;

endpackage

>>> rtl/core/cpa_update.sv
// Update logic of the consensus profile accumulator.
// Computes the new count row, cluster entry and result from the forwarded entries.
// Depends on cpa_pkg.
module cpa_update #(
    parameter int ALPHABET   = 4,
    parameter int COUNT_BITS = 16,
    parameter int LB         = 2
) (
    input  cpa_pkg::in_t                       item,
    input  logic [LB-1:0]                      let_idx,
    input  logic                               pos_ok,
    input  logic [ALPHABET*COUNT_BITS+LB-1:0]  row_cur,
    input  cpa_pkg::clu_entry_t                clu_cur,
    output logic [ALPHABET*COUNT_BITS+LB-1:0]  row_new,
    output cpa_pkg::clu_entry_t                clu_new,
    output cpa_pkg::out_t                      result,
    output cpa_pkg::upd_ctl_t                  ctl
);
    import cpa_pkg::*;

    localparam int CNT_W = ALPHABET * COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] cnt     [ALPHABET];
    logic [COUNT_BITS-1:0] cnt_out [ALPHABET];
    logic [COUNT_BITS-1:0] cnt_new;
    logic [LB-1:0]         cons_old;
    logic [LB-1:0]         cons_new;
    logic                  in_len;

    always_comb
    begin
        for (int a = 0; a < ALPHABET; a++)
        begin
            cnt[a] = row_cur[a*COUNT_BITS +: COUNT_BITS];
        end
    end

    always_comb
    begin
        for (int a = 0; a < ALPHABET; a++)
        begin
            cnt_out[a] = cnt[a];
        end
        cons_old = row_cur[CNT_W +: LB];
        cons_new = cons_old;
        cnt_new  = cnt[let_idx];
        clu_new  = clu_cur;
        ctl      = '0;
        in_len   = {1'b0, item.position} < clu_cur.len;
        result   = '0;

        if (item.action == ACTION_SEED)
        begin
            if (pos_ok)
            begin
                for (int a = 0; a < ALPHABET; a++)
                begin
                    cnt_out[a] = (LB'(a) == let_idx) ? COUNT_BITS'(1) : '0;
                end
                cnt_new    = COUNT_BITS'(1);
                cons_new   = let_idx;
                ctl.row_we = 1'b1;
                ctl.clu_we = 1'b1;
                if (item.last)
                begin
                    clu_new.len     = LEN_BITS'(item.position) + LEN_BITS'(1);
                    clu_new.members = MEMBER_BITS'(1);
                end
                result.consensus_letter = 2'(let_idx);
                result.letter_count     = 16'd1;
                result.member_count     = clu_new.members;
                result.ignored          = 1'b0;
            end
            else
            begin
                result.member_count = clu_cur.members;
                result.ignored      = 1'b1;
            end
        end
        else
        begin
            ctl.clu_we = 1'b1;
            if (item.last && clu_cur.members != MEMBER_MAX)
            begin
                clu_new.members = clu_cur.members + MEMBER_BITS'(1);
            end
            if (!in_len || !pos_ok)
            begin
                result.member_count = clu_new.members;
                result.ignored      = 1'b1;
            end
            else
            begin
                if (cnt[let_idx] != COUNT_MAX)
                begin
                    cnt_new = cnt[let_idx] + COUNT_BITS'(1);
                end
                cnt_out[let_idx] = cnt_new;
                // Ties keep the old consensus; the old letter's count is unchanged here.
                if (let_idx != cons_old && cnt_new > cnt[cons_old])
                begin
                    cons_new = let_idx;
                end
                ctl.row_we = 1'b1;
                result.consensus_letter = 2'(cons_new);
                result.letter_count     = 16'(cnt_new);
                result.member_count     = clu_new.members;
                result.ignored          = 1'b0;
            end
        end
    end

    always_comb
    begin
        row_new = '0;
        for (int a = 0; a < ALPHABET; a++)
        begin
            row_new[a*COUNT_BITS +: COUNT_BITS] = cnt_out[a];
        end
        row_new[CNT_W +: LB] = cons_new;
    end

endmodule

>>> rtl/core/consensus_profile_accumulator.sv
// Consensus profile accumulator: per cluster and position letter counts and consensus.
//
// Usage: letters enter on the item channel (item_valid, item_stall, item) and one
// result leaves for each on the result channel (result_valid, result_stall, result).
// A transaction completes at a clock edge with valid high and stall low.
// Each accepted letter reads its count row and its cluster entry from two synchronous
// memories, is updated in the update stage and written back when it leaves it; the result register
// is loaded at that same edge, so a result is offered once its letter leaves the update stage.
// Back-to-back letters to the same row or cluster are served by a forwarding
// register holding the most recent write of each memory, so one letter is taken
// every cycle unless a held result or the clearing pass raises item_stall.
// When result_stall holds a waiting result, the update stage keeps its letter until
// the result register frees, and item_stall stays high meanwhile.
// After reset a clearing pass zeroes every entry of the cluster table (lengths
// and member counts) with item_stall high. The count rows have no reset and are
// valid once a seed has written them.
module consensus_profile_accumulator #(
    parameter int CLUSTERS   = 16,
    parameter int POSITIONS  = 256,
    parameter int ALPHABET   = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  cpa_pkg::in_t  item,
    output logic          result_valid,
    input  logic          result_stall,
    output cpa_pkg::out_t result
);
    import cpa_pkg::*;

    localparam int CW    = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
    localparam int CELLS = CLUSTERS * POSITIONS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LB    = $clog2(ALPHABET);
    localparam int RW    = ALPHABET * COUNT_BITS + LB;

    logic [RW-1:0] row_mem [CELLS];
    clu_entry_t    clu_mem [CLUSTERS];

    logic          accept;
    logic          s1_adv;
    logic [CW-1:0] c_idx;
    logic [LB-1:0] let_idx;
    logic [AW-1:0] row_addr;
    logic          pos_ok;

    logic          clr_active_reg, clr_active_next;
    logic [CW-1:0] clr_idx_reg, clr_idx_next;

    logic          s1_valid_reg, s1_valid_next;
    in_t           s1_item_reg;
    logic [CW-1:0] s1_c_reg;
    logic [LB-1:0] s1_let_reg;
    logic [AW-1:0] s1_cell_reg;
    logic          s1_pos_ok_reg;

    logic [RW-1:0] row_rd_reg;
    clu_entry_t    clu_rd_reg;

    logic          row_fw_valid_reg;
    logic [AW-1:0] row_fw_addr_reg;
    logic [RW-1:0] row_fw_data_reg;
    logic          clu_fw_valid_reg;
    logic [CW-1:0] clu_fw_addr_reg;
    clu_entry_t    clu_fw_data_reg;

    logic [RW-1:0] row_cur;
    logic [RW-1:0] row_new;
    clu_entry_t    clu_cur;
    clu_entry_t    clu_new;
    out_t          upd_result;
    upd_ctl_t      ctl;
    logic          row_we;
    logic          clu_we;
    logic [CW-1:0] clu_wr_addr;
    clu_entry_t    clu_wr_data;

    logic          result_valid_reg, result_valid_next;
    out_t          result_reg;

    // Field reduction by the configured sizes, as small constant tables.
    always_comb
    begin
        c_idx = '0;
        for (int i = 0; i < CLUSTER_FIELD_VALUES; i++)
        begin
            if (item.cluster == 4'(i))
            begin
                c_idx = CW'(i % CLUSTERS);
            end
        end
        let_idx = '0;
        for (int i = 0; i < LETTER_FIELD_VALUES; i++)
        begin
            if (item.letter == 2'(i))
            begin
                let_idx = LB'(i % ALPHABET);
            end
        end
    end

    assign pos_ok   = 32'(item.position) < 32'(POSITIONS);
    assign row_addr = AW'(32'(c_idx) * 32'(POSITIONS) + 32'(item.position));

    assign s1_adv     = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = clr_active_reg || (s1_valid_reg && !s1_adv);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            clr_idx_next = clr_idx_reg + CW'(1);
            if (clr_idx_reg == CW'(CLUSTERS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end

        priority if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        priority if (s1_adv)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg   <= 1'b1;
            clr_idx_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            row_fw_valid_reg <= 1'b0;
            clu_fw_valid_reg <= 1'b0;
        end
        else
        begin
            clr_active_reg   <= clr_active_next;
            clr_idx_reg      <= clr_idx_next;
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (row_we)
            begin
                row_fw_valid_reg <= 1'b1;
            end
            if (clu_we && !clr_active_reg)
            begin
                clu_fw_valid_reg <= 1'b1;
            end
        end
    end

    // Stage payload, forwarding data and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg   <= item;
            s1_c_reg      <= c_idx;
            s1_let_reg    <= let_idx;
            s1_cell_reg   <= row_addr;
            s1_pos_ok_reg <= pos_ok;
        end
        if (row_we)
        begin
            row_fw_addr_reg <= s1_cell_reg;
            row_fw_data_reg <= row_new;
        end
        if (clu_we && !clr_active_reg)
        begin
            clu_fw_addr_reg <= s1_c_reg;
            clu_fw_data_reg <= clu_new;
        end
        if (s1_adv)
        begin
            result_reg <= upd_result;
        end
    end

    // A read at the edge of a write returns old data; the forwarding register fills in.
    assign row_cur = (row_fw_valid_reg && row_fw_addr_reg == s1_cell_reg)
                     ? row_fw_data_reg : row_rd_reg;
    assign clu_cur = (clu_fw_valid_reg && clu_fw_addr_reg == s1_c_reg)
                     ? clu_fw_data_reg : clu_rd_reg;

    cpa_update #(
        .ALPHABET   (ALPHABET),
        .COUNT_BITS (COUNT_BITS),
        .LB         (LB)
    ) u_update (
        .item    (s1_item_reg),
        .let_idx (s1_let_reg),
        .pos_ok  (s1_pos_ok_reg),
        .row_cur (row_cur),
        .clu_cur (clu_cur),
        .row_new (row_new),
        .clu_new (clu_new),
        .result  (upd_result),
        .ctl     (ctl)
    );

    assign row_we      = s1_adv && ctl.row_we;
    assign clu_we      = clr_active_reg || (s1_adv && ctl.clu_we);
    assign clu_wr_addr = clr_active_reg ? clr_idx_reg : s1_c_reg;
    assign clu_wr_data = clr_active_reg ? clu_entry_t'('0) : clu_new;

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[s1_cell_reg] <= row_new;
        end
        if (accept)
        begin
            row_rd_reg <= row_mem[row_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clu_we)
        begin
            clu_mem[clu_wr_addr] <= clu_wr_data;
        end
        if (accept)
        begin
            clu_rd_reg <= clu_mem[c_idx];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_cell_reg))
        else $error("update stage lost its transaction while blocked");

    a_row_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> s1_valid_reg && s1_pos_ok_reg)
        else $error("count row written for a position out of range");

    a_ignored_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.ignored
        |-> result_reg.letter_count == 16'd0 && result_reg.consensus_letter == 2'd0)
        else $error("ignored result carries letter fields");

    a_seed_count: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_item_reg.action == ACTION_SEED && s1_pos_ok_reg
        |=> result_reg.letter_count == 16'd1 && !result_reg.ignored)
        else $error("seed result does not report a count of one");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_active_reg |=> !clr_active_reg)
        else $error("clearing pass restarted without reset");

endmodule

>>> tb/tb_consensus_profile_accumulator.sv
// Self-checking testbench for consensus_profile_accumulator.
// Drives letters through a directed table and random seed/add sequences with one long
// result hold-off, and checks every result against a profile model or typed-in values. Depends on cpa_pkg.
module tb_consensus_profile_accumulator;
    timeunit 1ns;
    timeprecision 1ps;

    import cpa_pkg::*;

    localparam logic [15:0] COUNT_LIMIT   = 16'hFFFF;
    localparam int          CELLS         = 4096;
    localparam int          DIRECTED_ROWS = 18;

    typedef struct packed {
        in_t  stim;
        logic pinned;
        out_t want;
    } letter_case_t;

    logic clk          = 1'b0;
    logic rst_n        = 1'b0;
    logic item_valid   = 1'b0;
    logic item_stall;
    in_t  item         = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    out_t result;

    consensus_profile_accumulator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #4 clk = ~clk;

    // Profile model state.
    logic [15:0] prof_count [CELLS][4];
    logic [1:0]  prof_cons [CELLS];
    bit          prof_written [CELLS];
    logic [8:0]  clu_len [16];
    logic [15:0] clu_mem [16];

    out_t pending_profiles [$];
    out_t pinned_results [$];
    bit   pinned_flags [$];

    int unsigned mismatches     = 0;
    int unsigned letters_in     = 0;
    int unsigned results_seen   = 0;
    int unsigned ignored_seen   = 0;
    int unsigned send_idle_pct  = 16;
    int unsigned recv_stall_pct = 58;

    // Expected values are typed in only where they follow directly from the rules;
    // rows with pinned low are checked against the profile model.
    letter_case_t directed_rows [DIRECTED_ROWS] = '{
        // Nothing seeded after reset, so the letter is ignored.
        '{'{ACTION_ADD,  4'd0,  8'd0,   2'd0, 1'b0}, 1'b1, '{2'd0, 16'd0, 16'd0, 1'b1}},
        // Membership counts even when the letter is ignored.
        '{'{ACTION_ADD,  4'd15, 8'd255, 2'd3, 1'b1}, 1'b1, '{2'd0, 16'd0, 16'd1, 1'b1}},
        '{'{ACTION_SEED, 4'd3,  8'd0,   2'd3, 1'b0}, 1'b1, '{2'd3, 16'd1, 16'd0, 1'b0}},
        '{'{ACTION_SEED, 4'd3,  8'd1,   2'd0, 1'b1}, 1'b1, '{2'd0, 16'd1, 16'd1, 1'b0}},
        // A tie keeps the old consensus, a strictly larger count replaces it.
        '{'{ACTION_ADD,  4'd3,  8'd0,   2'd1, 1'b0}, 1'b1, '{2'd3, 16'd1, 16'd1, 1'b0}},
        '{'{ACTION_ADD,  4'd3,  8'd0,   2'd1, 1'b0}, 1'b1, '{2'd1, 16'd2, 16'd1, 1'b0}},
        '{'{ACTION_ADD,  4'd3,  8'd0,   2'd3, 1'b0}, 1'b1, '{2'd1, 16'd2, 16'd1, 1'b0}},
        '{'{ACTION_ADD,  4'd3,  8'd1,   2'd2, 1'b1}, 1'b0, '0},
        '{'{ACTION_ADD,  4'd3,  8'd2,   2'd0, 1'b1}, 1'b1, '{2'd0, 16'd0, 16'd3, 1'b1}},
        '{'{ACTION_SEED, 4'd15, 8'd255, 2'd2, 1'b1}, 1'b1, '{2'd2, 16'd1, 16'd1, 1'b0}},
        '{'{ACTION_ADD,  4'd15, 8'd255, 2'd2, 1'b1}, 1'b0, '0},
        '{'{ACTION_ADD,  4'd15, 8'd255, 2'd1, 1'b0}, 1'b0, '0},
        // Seeding again shortens the cluster.
        '{'{ACTION_SEED, 4'd3,  8'd0,   2'd2, 1'b1}, 1'b1, '{2'd2, 16'd1, 16'd1, 1'b0}},
        '{'{ACTION_ADD,  4'd3,  8'd1,   2'd0, 1'b0}, 1'b1, '{2'd0, 16'd0, 16'd1, 1'b1}},
        '{'{ACTION_ADD,  4'd3,  8'd0,   2'd0, 1'b1}, 1'b0, '0},
        '{'{ACTION_SEED, 4'd0,  8'd0,   2'd0, 1'b1}, 1'b1, '{2'd0, 16'd1, 16'd1, 1'b0}},
        '{'{ACTION_ADD,  4'd0,  8'd0,   2'd0, 1'b0}, 1'b1, '{2'd0, 16'd2, 16'd1, 1'b0}},
        '{'{ACTION_SEED, 4'd15, 8'd7,   2'd1, 1'b0}, 1'b1, '{2'd1, 16'd1, 16'd2, 1'b0}}
    };

    function automatic out_t update_profile(input in_t it);
        logic [11:0] cellx;
        logic [3:0]  c;
        out_t        r;
        int          a;
        cellx = {it.cluster, it.position};
        c     = it.cluster;
        r     = '0;
        if (it.action == ACTION_SEED) begin
            for (a = 0; a < 4; a++)
                prof_count[cellx][a] = '0;
            prof_count[cellx][it.letter] = 16'd1;
            prof_cons[cellx]             = it.letter;
            prof_written[cellx]          = 1'b1;
            if (it.last) begin
                clu_len[c] = it.position + 9'd1;
                clu_mem[c] = 16'd1;
            end
            r.consensus_letter = it.letter;
            r.letter_count     = 16'd1;
            r.member_count     = clu_mem[c];
        end
        else begin
            if (it.last && clu_mem[c] != MEMBER_MAX)
                clu_mem[c] = clu_mem[c] + 16'd1;
            r.member_count = clu_mem[c];
            if ({1'b0, it.position} >= clu_len[c]) begin
                r.ignored = 1'b1;
            end
            else begin
                if (prof_count[cellx][it.letter] != COUNT_LIMIT)
                    prof_count[cellx][it.letter] = prof_count[cellx][it.letter] + 16'd1;
                if (it.letter != prof_cons[cellx] &&
                    prof_count[cellx][it.letter] > prof_count[cellx][prof_cons[cellx]])
                    prof_cons[cellx] = it.letter;
                r.consensus_letter = prof_cons[cellx];
                r.letter_count     = prof_count[cellx][it.letter];
            end
        end
        return r;
    endfunction

    // An add inside the stored length must only land on a position that a seed wrote.
    function automatic in_t make_safe(input in_t it);
        if (it.action == ACTION_ADD && {1'b0, it.position} < clu_len[it.cluster] &&
            !prof_written[{it.cluster, it.position}])
            it.action = ACTION_SEED;
        return it;
    endfunction

    task automatic accept_letter(input in_t it);
        out_t want;
        out_t pinned_want;
        want = update_profile(it);
        if (pinned_flags.size() != 0) begin
            pinned_want = pinned_results.pop_front();
            if (pinned_flags.pop_front())
                want = pinned_want;
        end
        pending_profiles.push_back(want);
        letters_in++;
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        results_seen++;
        if (got.ignored)
            ignored_seen++;
        if (pending_profiles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with no letter outstanding: %p", $time, got);
            return;
        end
        want = pending_profiles.pop_front();
        if (got.consensus_letter !== want.consensus_letter ||
            got.letter_count !== want.letter_count ||
            got.member_count !== want.member_count ||
            got.ignored !== want.ignored) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: expected cons %0d count %0d members %0d ignored %0b, ",
                          "got cons %0d count %0d members %0d ignored %0b"},
                         $time, want.consensus_letter, want.letter_count, want.member_count,
                         want.ignored, got.consensus_letter, got.letter_count,
                         got.member_count, got.ignored);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && !result_stall)
                check_result(result);
            if (item_valid && !item_stall)
                accept_letter(item);
        end
    end

    // Result side back-pressure, with one long hold-off so the pipeline fills up.
    int unsigned hold_left     = 0;
    bit          pressure_done = 1'b0;

    always @(negedge clk) begin
        if (hold_left != 0) begin
            result_stall <= 1'b1;
            hold_left    <= hold_left - 1;
        end
        else if (!pressure_done && letters_in >= 150) begin
            result_stall  <= 1'b1;
            hold_left     <= 300;
            pressure_done <= 1'b1;
        end
        else begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send(input in_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly well-formed seed and add sequences, with broken ones and single random letters.
    task automatic run_random(input int unsigned n_items);
        in_t         seq [$];
        in_t         it;
        int unsigned sent;
        int unsigned kind;
        int unsigned mode;
        int unsigned span;
        int unsigned bias;
        int unsigned tries;
        int unsigned p;
        logic [3:0]  c;
        sent = 0;
        while (sent < n_items) begin
            seq.delete();
            kind = $urandom_range(99);
            c    = 4'($urandom_range(15));
            mode = $urandom_range(9);
            if (kind < 30) begin
                kind = $urandom_range(99);
                if (kind < 80)
                    span = $urandom_range(1, 12);
                else if (kind < 95)
                    span = $urandom_range(13, 64);
                else
                    span = $urandom_range(65, 256);
                for (p = 0; p < span; p++) begin
                    it.action   = ACTION_SEED;
                    it.cluster  = c;
                    it.position = 8'(p);
                    it.letter   = 2'($urandom_range(3));
                    it.last     = (p == span - 1) && (mode != 0);
                    seq.push_back(it);
                end
            end
            else if (kind < 75) begin
                tries = 0;
                while (clu_len[c] == 0 && tries < 8) begin
                    c = 4'($urandom_range(15));
                    tries++;
                end
                span = 32'(clu_len[c]);
                if (mode == 0)
                    span = span + $urandom_range(1, 3);
                else if (mode == 1 && span > 1)
                    span = $urandom_range(1, span - 1);
                if (span == 0)
                    span = $urandom_range(1, 3);
                if (span > 256)
                    span = 256;
                bias = $urandom_range(3);
                for (p = 0; p < span; p++) begin
                    it.action   = ACTION_ADD;
                    it.cluster  = c;
                    it.position = 8'(p);
                    it.letter   = ($urandom_range(99) < 60) ? 2'(p + bias) :
                                  2'($urandom_range(3));
                    it.last     = (p == span - 1) && (mode != 2);
                    seq.push_back(it);
                end
            end
            else begin
                it = in_t'(16'($urandom));
                seq.push_back(it);
            end
            while (seq.size() != 0) begin
                it = make_safe(seq.pop_front());
                send(it);
                sent++;
            end
        end
    endtask

    initial begin
        int r;
        for (r = 0; r < 16; r++) begin
            clu_len[r] = '0;
            clu_mem[r] = '0;
        end
        for (r = 0; r < CELLS; r++)
            prof_written[r] = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            pinned_flags.push_back(directed_rows[r].pinned);
            pinned_results.push_back(directed_rows[r].want);
            send(directed_rows[r].stim);
        end

        run_random(400);
        send_idle_pct  = 58;
        recv_stall_pct = 16;
        run_random(400);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(400);

        item_valid <= 1'b0;
        while (pending_profiles.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        mismatches = mismatches + pending_profiles.size();

        $display("Sent %0d letters and checked %0d results; %0d were flagged as ignored.",
                 letters_in, results_seen, ignored_seen);
        $display("Covered three idle mixes and one long result hold-off; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #4000000;
        $display("Run timed out with %0d results outstanding.", pending_profiles.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/cpa_pkg.sv
rtl/core/cpa_update.sv
rtl/core/consensus_profile_accumulator.sv
tb/tb_consensus_profile_accumulator.sv
